// File: hw/rtl/ahpc_pkg.sv
// ----------------------------------------------------------------------------
// ahpc_pkg
// Shared types and constants for the axis-aligned half-plane polygon clipper.
// ----------------------------------------------------------------------------
package ahpc_pkg;

    localparam int COORD_W          = 32;
    localparam int DEF_MAX_VERTICES = 16;
    localparam int OUT_CAP          = 32;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_HORIZONTAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_COORD      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_LOWER_SIDE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CUT_MODE        = 3'd3;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_point;

endpackage

// File: hw/rtl/ahpc_vtx_if.sv
// ----------------------------------------------------------------------------
// ahpc_vtx_if
// Vertex input channel: one polygon vertex per request, last marks the end.
// ----------------------------------------------------------------------------
interface ahpc_vtx_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [ahpc_pkg::COORD_W-1:0]  vertex_x;
    logic signed [ahpc_pkg::COORD_W-1:0]  vertex_y;
    logic                                 vertex_last;

    modport source (output valid, vertex_x, vertex_y, vertex_last, input ready);
    modport sink   (input valid, vertex_x, vertex_y, vertex_last, output ready);
endinterface

// File: hw/rtl/ahpc_res_if.sv
// ----------------------------------------------------------------------------
// ahpc_res_if
// Result channel: one clipped vertex per request, last marks the end.
// ----------------------------------------------------------------------------
interface ahpc_res_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [ahpc_pkg::COORD_W-1:0]  out_x;
    logic signed [ahpc_pkg::COORD_W-1:0]  out_y;
    logic                                 out_valid;
    logic                                 out_last;

    modport source (output valid, out_x, out_y, out_valid, out_last, input ready);
    modport sink   (input valid, out_x, out_y, out_valid, out_last, output ready);
endinterface

// File: hw/rtl/axis_halfplane_polygon_clip_unit.sv
// ----------------------------------------------------------------------------
// axis_halfplane_polygon_clip_unit
// Clips a polygon against one axis-aligned half-plane.
// ----------------------------------------------------------------------------
// Usage:
//   i_vtx carries vertices, one request each, one per cycle while loading;
//   the request with vertex_last set closes the polygon. Vertices past
//   MAX_VERTICES are dropped, but their last flag still counts.
//   The block then walks the stored ring edge by edge, and each crossing
//   point comes from the bit-serial 64-by-32 divider (one quotient bit per
//   cycle). Results leave on o_res, each vertex through the result memory
//   read and the output register; an empty polygon gives one request with
//   out_valid low. i_vtx is not ready while a polygon is being clipped.
//   When o_res stalls, the output register holds its request and the block
//   waits; no new vertex is taken until the whole result is delivered.
//   Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data; the
//   user must write it only while idle, as the block does not enforce this.
//   Reset (i_rst_n low, synchronous) clears the counts and the control and
//   configuration registers; the vertex memories need no clearing.
// ----------------------------------------------------------------------------
module axis_halfplane_polygon_clip_unit #(
    parameter int MAX_VERTICES = ahpc_pkg::DEF_MAX_VERTICES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    ahpc_vtx_if.sink                            i_vtx,
    ahpc_res_if.source                          o_res,
    input  logic                                i_cfg_we,
    input  logic [ahpc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ahpc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import ahpc_pkg::*;

    localparam int VA_W      = $clog2(MAX_VERTICES);
    localparam int VC_W      = $clog2(MAX_VERTICES + 1);
    localparam int C_DEPTH   = 2 * MAX_VERTICES;
    localparam int CA_W      = $clog2(C_DEPTH);
    localparam int CM_W      = $clog2(C_DEPTH + 1);
    localparam int EMIT_MAX  = (C_DEPTH < OUT_CAP) ? C_DEPTH : OUT_CAP;

    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_RDS   = 4'd1;
    localparam logic [3:0] S_LDS   = 4'd2;
    localparam logic [3:0] S_RDE   = 4'd3;
    localparam logic [3:0] S_EDGE  = 4'd4;
    localparam logic [3:0] S_DEC   = 4'd5;
    localparam logic [3:0] S_PREP  = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_XPT   = 4'd8;
    localparam logic [3:0] S_PUSHE = 4'd9;
    localparam logic [3:0] S_FIN   = 4'd10;
    localparam logic [3:0] S_ORD   = 4'd11;
    localparam logic [3:0] S_OCAP  = 4'd12;
    localparam logic [3:0] S_OWAIT = 4'd13;

    // configuration
    logic    r_horiz, r_keep_low, r_cut;
    t_coord  r_line;

    // control
    logic [3:0]      r_state;
    logic [VC_W-1:0] r_vcnt;
    logic [VC_W-1:0] r_i;
    logic [CM_W-1:0] r_m;
    logic [CM_W-1:0] r_j;
    logic [5:0]      r_k;
    logic            r_ovld;

    // datapath
    t_point          r_s, r_e, r_first, r_last;
    t_point          r_vrd, r_crd;
    logic signed [63:0] r_num;
    t_coord          r_den;
    logic [63:0]     r_dq;
    logic [31:0]     r_dd;
    logic [31:0]     r_rem;
    logic            r_neg;
    t_coord          r_ox, r_oy;
    logic            r_oflag, r_olast;

    t_point vmem [MAX_VERTICES];
    t_point cmem [C_DEPTH];

    logic [VA_W-1:0] w_vra;
    logic [CA_W-1:0] w_cra;

    // half-plane tests
    t_coord w_s_on, w_e_on, w_s_off, w_e_off;
    logic   w_s_in, w_e_in;

    assign w_s_on  = r_horiz ? r_s.y : r_s.x;
    assign w_e_on  = r_horiz ? r_e.y : r_e.x;
    assign w_s_off = r_horiz ? r_s.x : r_s.y;
    assign w_e_off = r_horiz ? r_e.x : r_e.y;
    assign w_s_in  = r_keep_low ? (w_s_on <= r_line) : (w_s_on >= r_line);
    assign w_e_in  = r_keep_low ? (w_e_on <= r_line) : (w_e_on >= r_line);

    // crossing numerator and denominator
    t_coord w_da, w_db;
    logic signed [63:0] w_prod;
    assign w_da   = r_line - w_s_on;
    assign w_db   = w_e_off - w_s_off;
    assign w_prod = w_da * w_db;

    // restoring divider step
    logic [32:0] w_rsh;
    logic        w_ge;
    logic [32:0] w_rsub;
    assign w_rsh  = {r_rem, r_dq[63]};
    assign w_ge   = w_rsh >= {1'b0, r_dd};
    assign w_rsub = w_rsh - {1'b0, r_dd};

    // crossing point from quotient
    t_coord w_q, w_off;
    t_point w_xp;
    assign w_q   = r_neg ? -r_dq[31:0] : r_dq[31:0];
    assign w_off = w_s_off + w_q;
    always_comb begin
        if (r_horiz) begin
            w_xp.x = w_off;
            w_xp.y = r_line;
        end else begin
            w_xp.x = r_line;
            w_xp.y = w_off;
        end
    end

    // push into result memory with duplicate merge
    logic   w_push, w_push_do;
    t_point w_pp;
    always_comb begin
        w_push = 1'b0;
        w_pp   = r_e;
        unique case (r_state)
            S_DEC: begin
                w_push = (w_e_in != w_s_in) && (w_s_on == w_e_on);
                w_pp   = r_s;
            end
            S_XPT: begin
                w_push = 1'b1;
                w_pp   = w_xp;
            end
            S_PUSHE: begin
                w_push = w_e_in;
                w_pp   = r_e;
            end
            default: ;
        endcase
    end
    assign w_push_do = w_push && !((r_m != '0) && (w_pp == r_last));

    // final count after closing merge and cut-mode minimum
    logic [CM_W-1:0] w_mfin, w_emit;
    always_comb begin
        w_mfin = r_m;
        if ((r_m >= CM_W'(2)) && (r_first == r_last)) w_mfin = r_m - 1'b1;
        if (r_cut && (w_mfin < CM_W'(3))) w_mfin = '0;
    end
    assign w_emit = (int'(r_m) > EMIT_MAX) ? CM_W'(EMIT_MAX) : r_m;

    // nudge of points on an odd line in cut mode
    t_point w_np;
    t_coord w_step;
    logic   w_nudge;
    assign w_nudge = r_cut && r_line[0];
    assign w_step  = r_keep_low ? -32'sd1 : 32'sd1;
    always_comb begin
        w_np = r_crd;
        if (w_nudge) begin
            if (r_horiz) begin
                if (r_crd.y == r_line) w_np.y = r_crd.y + w_step;
            end else begin
                if (r_crd.x == r_line) w_np.x = r_crd.x + w_step;
            end
        end
    end

    // memory addresses
    assign w_vra = (r_state == S_RDS) ? VA_W'(r_vcnt - 1'b1) : r_i[VA_W-1:0];
    assign w_cra = r_j[CA_W-1:0];

    logic w_in_acc, w_out_acc;
    assign i_vtx.ready = (r_state == S_LOAD);
    assign w_in_acc    = i_vtx.valid && (r_state == S_LOAD);
    assign w_out_acc   = r_ovld && o_res.ready;

    // vertex memory
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (r_vcnt < VC_W'(MAX_VERTICES))) begin
            vmem[r_vcnt[VA_W-1:0]] <= '{x: i_vtx.vertex_x, y: i_vtx.vertex_y};
        end
        r_vrd <= vmem[w_vra];
    end

    // result memory
    always_ff @(posedge i_clk) begin
        if (w_push_do) cmem[r_m[CA_W-1:0]] <= w_pp;
        r_crd <= cmem[w_cra];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_horiz    <= 1'b0;
            r_line     <= '0;
            r_keep_low <= 1'b0;
            r_cut      <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CLIP_HORIZONTAL: r_horiz    <= i_cfg_data[0];
                CFG_LINE_COORD:      r_line     <= i_cfg_data;
                CFG_KEEP_LOWER_SIDE: r_keep_low <= i_cfg_data[0];
                CFG_CUT_MODE:        r_cut      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_vcnt  <= '0;
            r_i     <= '0;
            r_m     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_ovld  <= 1'b0;
        end else begin
            if (w_push_do) r_m <= r_m + 1'b1;
            unique case (r_state)
                S_LOAD: begin
                    if (w_in_acc) begin
                        if (r_vcnt < VC_W'(MAX_VERTICES)) r_vcnt <= r_vcnt + 1'b1;
                        if (i_vtx.vertex_last) begin
                            r_m     <= '0;
                            r_state <= S_RDS;
                        end
                    end
                end
                S_RDS:  r_state <= (r_vcnt == '0) ? S_FIN : S_LDS;
                S_LDS: begin
                    r_i     <= '0;
                    r_state <= S_RDE;
                end
                S_RDE:  r_state <= S_EDGE;
                S_EDGE: r_state <= S_DEC;
                S_DEC: begin
                    if ((w_e_in != w_s_in) && (w_s_on != w_e_on)) r_state <= S_PREP;
                    else r_state <= S_PUSHE;
                end
                S_PREP: begin
                    r_k     <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_k <= r_k + 1'b1;
                    if (r_k == 6'd63) r_state <= S_XPT;
                end
                S_XPT:  r_state <= S_PUSHE;
                S_PUSHE: begin
                    if (r_i == r_vcnt - 1'b1) begin
                        r_state <= S_FIN;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_RDE;
                    end
                end
                S_FIN: begin
                    r_m <= w_mfin;
                    r_j <= '0;
                    if (w_mfin == '0) begin
                        r_ovld  <= 1'b1;
                        r_state <= S_OWAIT;
                    end else begin
                        r_state <= S_ORD;
                    end
                end
                S_ORD:  r_state <= S_OCAP;
                S_OCAP: begin
                    r_ovld  <= 1'b1;
                    r_state <= S_OWAIT;
                end
                S_OWAIT: begin
                    if (w_out_acc) begin
                        r_ovld <= 1'b0;
                        if (r_olast) begin
                            r_vcnt  <= '0;
                            r_state <= S_LOAD;
                        end else begin
                            r_j     <= r_j + 1'b1;
                            r_state <= S_ORD;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_LDS:  r_s <= r_vrd;
            S_EDGE: r_e <= r_vrd;
            S_DEC: begin
                r_num <= w_prod;
                r_den <= w_e_on - w_s_on;
            end
            S_PREP: begin
                r_dq  <= r_num[63] ? 64'(-r_num) : 64'(r_num);
                r_dd  <= r_den[31] ? 32'(-r_den) : 32'(r_den);
                r_rem <= '0;
                r_neg <= r_num[63] ^ r_den[31];
            end
            S_DIV: begin
                r_dq  <= {r_dq[62:0], w_ge};
                r_rem <= w_ge ? w_rsub[31:0] : w_rsh[31:0];
            end
            S_PUSHE: r_s <= r_e;
            S_FIN: begin
                r_ox    <= '0;
                r_oy    <= '0;
                r_oflag <= 1'b0;
                r_olast <= 1'b1;
            end
            S_OCAP: begin
                r_ox    <= w_np.x;
                r_oy    <= w_np.y;
                r_oflag <= 1'b1;
                r_olast <= (r_j == w_emit - 1'b1);
            end
            default: ;
        endcase
        if (w_push_do) begin
            r_last <= w_pp;
            if (r_m == '0) r_first <= w_pp;
        end
    end

    assign o_res.valid     = r_ovld;
    assign o_res.out_x     = r_ox;
    assign o_res.out_y     = r_oy;
    assign o_res.out_valid = r_oflag;
    assign o_res.out_last  = r_olast;

endmodule

// File: tb/tb_axis_halfplane_polygon_clip_unit.sv
// ----------------------------------------------------------------------------
// tb_axis_halfplane_polygon_clip_unit
// Sends polygons with random idling, predicts the clipped vertex runs in a
// behavioral model and compares every result request field by field.
// ----------------------------------------------------------------------------
module tb_axis_halfplane_polygon_clip_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import ahpc_pkg::*;

    localparam int NVTX      = DEF_MAX_VERTICES;
    localparam int WDOG_MAX  = 20000;

    // index past the register list, written to check that it is ignored
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = '1;

    typedef struct packed {
        t_coord x;
        t_coord y;
        logic   vld;
        logic   last;
    } t_res;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ahpc_vtx_if vtx ();
    ahpc_res_if res ();

    axis_halfplane_polygon_clip_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vtx      (vtx.sink),
        .o_res      (res.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // predictor state
    logic   clip_hor;
    t_coord line_c;
    logic   keep_low;
    logic   cut_on;
    t_point poly[NVTX];
    int     poly_len;
    t_res   expected_q[$];

    int  fail_cnt = 0;
    int  idle_cycles = 0;
    bit  rx_hold;
    bit  quiet_rx;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // watchdog on cycles with no request
    always @(posedge i_clk) begin
        if ((vtx.valid && vtx.ready) || (res.valid && res.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WDOG_MAX) begin
            $display("axis_halfplane_polygon_clip_unit: mismatch");
            $finish;
        end
    end

    function automatic bit keeps(t_point p);
        t_coord c;
        c = clip_hor ? p.y : p.x;
        return keep_low ? (c <= line_c) : (c >= line_c);
    endfunction

    function automatic t_point cross_pt(t_point a, t_point b);
        t_coord a_on, b_on, a_off, b_off, dl, doff, den;
        longint num;
        t_coord off;
        t_point r;
        a_on  = clip_hor ? a.y : a.x;
        b_on  = clip_hor ? b.y : b.x;
        a_off = clip_hor ? a.x : a.y;
        b_off = clip_hor ? b.x : b.y;
        if (a_on == b_on) return a;
        dl   = line_c - a_on;
        doff = b_off - a_off;
        den  = b_on - a_on;
        num  = longint'(dl) * longint'(doff);
        if (den == 0) off = a_off;
        else off = a_off + t_coord'(num / longint'(den));
        if (clip_hor) begin
            r.y = line_c; r.x = off;
        end else begin
            r.x = line_c; r.y = off;
        end
        return r;
    endfunction

    // clip the stored polygon and queue the expected results
    task automatic predict_clip();
        t_point pts[$];
        t_point mrg[$];
        t_point s, e;
        bit s_in, e_in;
        int n;
        t_res r;
        if (poly_len > 0) begin
            s = poly[poly_len-1];
            s_in = keeps(s);
            for (int i = 0; i < poly_len; i++) begin
                e = poly[i];
                e_in = keeps(e);
                if (e_in) begin
                    if (!s_in) pts.insert(pts.size(), cross_pt(s, e));
                    pts.insert(pts.size(), e);
                end else if (s_in) begin
                    pts.insert(pts.size(), cross_pt(s, e));
                end
                s = e;
                s_in = e_in;
            end
        end
        foreach (pts[i])
            if (mrg.size() == 0 || mrg[$] != pts[i]) mrg.insert(mrg.size(), pts[i]);
        if (mrg.size() >= 2 && mrg[0] == mrg[$]) mrg.delete(mrg.size() - 1);
        if (cut_on) begin
            if (line_c[0]) begin
                foreach (mrg[i]) begin
                    if (clip_hor && mrg[i].y == line_c)
                        mrg[i].y = keep_low ? line_c - 1 : line_c + 1;
                    if (!clip_hor && mrg[i].x == line_c)
                        mrg[i].x = keep_low ? line_c - 1 : line_c + 1;
                end
            end
            if (mrg.size() < 3) mrg.delete();
        end
        poly_len = 0;
        if (mrg.size() == 0) begin
            r = '{x: '0, y: '0, vld: 1'b0, last: 1'b1};
            expected_q.insert(expected_q.size(), r);
        end else begin
            n = (mrg.size() < OUT_CAP) ? mrg.size() : OUT_CAP;
            for (int i = 0; i < n; i++) begin
                r = '{x: mrg[i].x, y: mrg[i].y, vld: 1'b1, last: (i == n - 1)};
                expected_q.insert(expected_q.size(), r);
            end
        end
    endtask

    // stop offering vertex requests
    task automatic idle_input();
        vtx.valid <= 1'b0;
    endtask

    // send one vertex request and update the predictor
    task automatic send_vertex(t_coord x, t_coord y, logic last);
        t_point p;
        int gap;
        gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            vtx.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        vtx.valid       <= 1'b1;
        vtx.vertex_x    <= x;
        vtx.vertex_y    <= y;
        vtx.vertex_last <= last;
        do @(posedge i_clk); while (!vtx.ready);
        p.x = x;
        p.y = y;
        if (poly_len < NVTX) begin
            poly[poly_len] = p;
            poly_len++;
        end
        if (last) predict_clip();
    endtask

    task automatic send_poly(t_point pts[$]);
        foreach (pts[i]) send_vertex(pts[i].x, pts[i].y, i == pts.size() - 1);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        case (idx)
            CFG_CLIP_HORIZONTAL: clip_hor = d[0];
            CFG_LINE_COORD:      line_c   = d;
            CFG_KEEP_LOWER_SIDE: keep_low = d[0];
            CFG_CUT_MODE:        cut_on   = d[0];
            default: ;
        endcase
    endtask

    // wait for the block to drain, then write all registers
    task automatic set_clip(logic h, t_coord c, logic low, logic cut);
        idle_input();
        wait (expected_q.size() == 0);
        repeat (20) @(posedge i_clk);
        cfg_write(CFG_CLIP_HORIZONTAL, CFG_DATA_W'(h));
        cfg_write(CFG_LINE_COORD, c);
        cfg_write(CFG_KEEP_LOWER_SIDE, CFG_DATA_W'(low));
        cfg_write(CFG_CUT_MODE, CFG_DATA_W'(cut));
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_coord rand_coord(int mode);
        case (mode)
            0: return t_coord'($urandom_range(0, 40)) - 20;
            1: return $urandom;
            default: return ($urandom_range(0, 1) ? 32'h7fff_fff0 : 32'h8000_0000)
                            + $urandom_range(0, 15);
        endcase
    endfunction

    task automatic rand_poly(int mode);
        t_point pts[$];
        t_point p;
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 20) : $urandom_range(3, 8);
        repeat (n) begin
            p.x = rand_coord(mode);
            p.y = rand_coord(mode);
            pts.insert(pts.size(), p);
        end
        send_poly(pts);
    endtask

    // directed: square across the line, extremes, degenerate, too many vertices
    task automatic test_directed();
        t_point sq[$];
        t_point pts[$];
        t_point p;
        cfg_write(CFG_IDX_SPARE, '1);
        i_cfg_we <= 1'b0;
        sq = '{'{x: -4, y: -4}, '{x: 4, y: -4}, '{x: 4, y: 4}, '{x: -4, y: 4}};
        send_poly(sq);
        set_clip(1'b0, 1, 1'b1, 1'b1);
        send_poly(sq);
        set_clip(1'b1, -1, 1'b0, 1'b1);
        send_poly(sq);
        set_clip(1'b1, 32'sh7fff_ffff, 1'b1, 1'b0);
        pts = '{'{x: 32'sh8000_0000, y: 32'sh8000_0000},
                '{x: 32'sh7fff_ffff, y: 32'sh7fff_ffff},
                '{x: 32'sh7fff_ffff, y: 32'sh8000_0000}};
        send_poly(pts);
        set_clip(1'b0, 32'sh8000_0000, 1'b0, 1'b1);
        send_poly(pts);
        set_clip(1'b0, 100, 1'b0, 1'b0);
        send_poly(sq);
        pts = '{'{x: 0, y: 0}};
        send_poly(pts);
        pts.delete();
        for (int i = 0; i < 18; i++) begin
            p.x = i * 3 - 20;
            p.y = (i % 2) ? 7 : -7;
            pts.insert(pts.size(), p);
        end
        set_clip(1'b0, 0, 1'b1, 1'b0);
        send_poly(pts);
    endtask

    // random polygons under varied settings
    task automatic test_random();
        int sent;
        sent = 0;
        while (sent < 200) begin
            set_clip(1'($urandom_range(0, 1)),
                     rand_coord($urandom_range(0, 3) == 0 ? 1 : 0),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            repeat (6) begin
                rand_poly($urandom_range(0, 7) < 6 ? 0 : $urandom_range(1, 2));
                sent += 6;
            end
        end
    endtask

    // long receiver hold-off while the sender keeps offering
    task automatic test_backpressure();
        set_clip(1'b0, 0, 1'b0, 1'b0);
        rx_hold = 1'b1;
        fork
            repeat (400) @(posedge i_clk);
            repeat (4) rand_poly(0);
        join_any
        rx_hold = 1'b0;
        wait fork;
    endtask

    // result checker with random stalls
    initial begin
        int stall;
        t_res got, exp_r;
        res.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (res.valid && res.ready) begin
                got = '{x: res.out_x, y: res.out_y, vld: res.out_valid,
                        last: res.out_last};
                if (expected_q.size() == 0) begin
                    $error("result with no expectation x=%0d", got.x);
                    fail_cnt++;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (got.x != exp_r.x) begin
                        $error("out_x exp %0d got %0d", exp_r.x, got.x); fail_cnt++;
                    end
                    if (got.y != exp_r.y) begin
                        $error("out_y exp %0d got %0d", exp_r.y, got.y); fail_cnt++;
                    end
                    if (got.vld != exp_r.vld) begin
                        $error("out_valid exp %0b got %0b", exp_r.vld, got.vld); fail_cnt++;
                    end
                    if (got.last != exp_r.last) begin
                        $error("out_last exp %0b got %0b", exp_r.last, got.last); fail_cnt++;
                    end
                end
                stall = quiet_rx ? 0 : $urandom_range(0, 15);
                if (stall > 0 && $urandom_range(0, 2) != 0) begin
                    res.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            res.ready <= !rx_hold;
        end
    end

    initial begin
        vtx.valid = 1'b0;
        vtx.vertex_x = '0;
        vtx.vertex_y = '0;
        vtx.vertex_last = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        clip_hor = 1'b0; line_c = '0; keep_low = 1'b0; cut_on = 1'b0;
        poly_len = 0; rx_hold = 1'b0; quiet_rx = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        quiet_rx = 1'b1;
        test_random();
        quiet_rx = 1'b0;
        test_random();
        test_backpressure();
        idle_input();
        wait (expected_q.size() == 0);
        repeat (100) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("axis_halfplane_polygon_clip_unit: match");
        else
            $display("axis_halfplane_polygon_clip_unit: mismatch");
        $finish;
    end
endmodule
